// File: sv/radar_measurement_jacobian_macros.svh
// Assertion macros for the radar measurement Jacobian block
`ifndef RADAR_MEASUREMENT_JACOBIAN_MACROS_SVH
`define RADAR_MEASUREMENT_JACOBIAN_MACROS_SVH

// Same-cycle implication, checked out of reset
`define RMJ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define RMJ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/rmj_pkg.sv
// Shared constants and types for the radar measurement Jacobian block
`timescale 1ns / 1ps
`default_nettype none
package rmj_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int EPS_RESET     = 7;

  // Sign of each result, settled early and carried to the output stage
  typedef struct packed {
    logic x_neg;
    logic y_neg;
    logic y_pos;
    logic rdx_neg;
    logic rdy_neg;
  } neg_t;

endpackage
`default_nettype wire

// File: sv/radar_measurement_jacobian.sv
// Radar measurement Jacobian: top level pipeline
//
// Input channel in_*: one planar state (pos_x, pos_y, vel_x, vel_y), signed
// fixed point, per beat. Output channel out_*: the six distinct nonzero
// Jacobian entries for that state, saturated to the signed word, one beat
// per input beat, in order. Config channel cfg_*: writes the epsilon floor
// applied to range squared, range and range cubed; cfg_ready is always high.
// Write it only while no beat is in flight. A floor of zero acts as one.
// The pipeline holds a root-bit-per-stage square root, a split wide
// multiply for range cubed and six quotient-bit-per-stage dividers in
// parallel. Throughput is one beat per cycle unless the output stalls.
// The whole pipeline advances together; when out_valid is high and
// out_ready low every stage holds and in_ready drops, so nothing is lost
// or repeated. Synchronous reset clears all valid bits and sets the floor
// to its reset value.
`timescale 1ns / 1ps
`default_nettype none
`include "radar_measurement_jacobian_macros.svh"
module radar_measurement_jacobian #(
  parameter int WORD_BITS = rmj_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = rmj_pkg::FRAC_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic signed [WORD_BITS-1:0] in_pos_x,
  input  wire logic signed [WORD_BITS-1:0] in_pos_y,
  input  wire logic signed [WORD_BITS-1:0] in_vel_x,
  input  wire logic signed [WORD_BITS-1:0] in_vel_y,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic signed [WORD_BITS-1:0]      out_range_dx,
  output logic signed [WORD_BITS-1:0]      out_range_dy,
  output logic signed [WORD_BITS-1:0]      out_bearing_dx,
  output logic signed [WORD_BITS-1:0]      out_bearing_dy,
  output logic signed [WORD_BITS-1:0]      out_rate_dx,
  output logic signed [WORD_BITS-1:0]      out_rate_dy,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [WORD_BITS-2:0]        cfg_data
);
  import rmj_pkg::*;

  localparam int W    = WORD_BITS;
  localparam int F    = FRAC_BITS;
  localparam int C1W  = 2 * W - F;
  localparam int C3W  = 3 * W - 2 * F;
  localparam int NRW  = 3 * W - F;
  localparam int QB   = W + 1;
  localparam int NGW  = $bits(neg_t);
  localparam int AW   = 2 * W + C1W + NGW + 2 * NRW;

  // saturate a magnitude and apply its sign
  function automatic logic [W-1:0] sat_pack(input logic neg, input logic [QB-1:0] m,
                                            input logic of);
    logic [QB-1:0] lim;
    logic [QB-1:0] mg;
    logic [QB-1:0] mg_n;
    lim  = neg ? (QB'(1) << (W - 1)) : ((QB'(1) << (W - 1)) - QB'(1));
    mg   = (of || (m > lim)) ? lim : m;
    mg_n = QB'(~mg + QB'(1));
    return neg ? mg_n[W-1:0] : mg[W-1:0];
  endfunction

  logic         en;
  logic         out_valid_r;
  logic [W-2:0] eps_r;
  logic [W-2:0] eps_eff;

  // pipeline advances whenever the output register is free or being taken
  assign en        = !out_valid_r || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;
  assign eps_eff   = (eps_r == '0) ? (W-1)'(1) : eps_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= (W-1)'(EPS_RESET);
    end else if (cfg_valid) begin
      eps_r <= cfg_data;
    end
  end

  // ---- stage 1: input register
  logic                v1_r;
  logic signed [W-1:0] x1_r, y1_r, vx1_r, vy1_r;

  // ---- stage 2: magnitudes, signs, cross products
  logic                  v2_r;
  logic [W-1:0]          ax2_r, ay2_r;
  logic                  xn2_r, yn2_r, yp2_r;
  logic signed [2*W-1:0] pa2_r, pb2_r;
  logic [W-1:0]          ax_nxt, ay_nxt;

  // ---- stage 3: squares and cross difference
  logic                v3_r;
  logic [2*W-1:0]      sqx3_r, sqy3_r;
  logic signed [2*W:0] d3_r;
  logic [W-1:0]        ax3_r, ay3_r;
  logic                xn3_r, yn3_r, yp3_r;

  // ---- stage 4: floored range squared, cross magnitude
  logic           v4_r;
  logic [C1W-1:0] c1_4_r;
  logic [2*W-1:0] ad4_r;
  logic           dn4_r, dp4_r;
  logic [W-1:0]   ax4_r, ay4_r;
  logic           xn4_r, yn4_r, yp4_r;
  logic [2*W-1:0] sq_sum;
  logic [C1W-1:0] c1_raw;
  logic [2*W:0]   d_abs;

  // ---- stage 5: rate numerator partial products
  logic           v5_r;
  logic [2*W-1:0] rxl5_r, rxh5_r, ryl5_r, ryh5_r;
  logic [W-1:0]   ax5_r, ay5_r;
  logic [C1W-1:0] c1_5_r;
  neg_t           ng5_r;

  // ---- stage 6: rate numerators
  logic           v6_r;
  logic [NRW-1:0] nrx6_r, nry6_r;
  logic [W-1:0]   ax6_r, ay6_r;
  logic [C1W-1:0] c1_6_r;
  neg_t           ng6_r;
  logic [3*W-1:0] nrx_full, nry_full;

  // ---- delay across the square root
  logic [AW-1:0]  dla_in, dla_out;
  logic           va;
  logic [W-1:0]   axa, aya;
  logic [C1W-1:0] c1a;
  neg_t           nga;
  logic [NRW-1:0] nrxa, nrya;
  logic [W-1:0]   root;
  logic [W-1:0]   c2_r;

  // ---- stage b: range cubed partial products
  logic               vb_r;
  logic [2*W-1:0]     plb_r;
  logic [C1W-1:0]     phb_r;
  logic [W-1:0]       axb_r, ayb_r, c2b_r;
  logic [C1W-1:0]     c1b_r;
  neg_t               ngb_r;
  logic [NRW-1:0]     nrxb_r, nryb_r;
  logic [C1W+W-1:0]   c3_full;
  logic [C3W-1:0]     c3_raw;

  // ---- stage c: divider operands
  logic           vc_r;
  logic [W-1:0]   axc_r, ayc_r, c2c_r;
  logic [C1W-1:0] c1c_r;
  logic [C3W-1:0] c3c_r;
  neg_t           ngc_r;
  logic [NRW-1:0] nrxc_r, nryc_r;

  // ---- divider outputs and carried signs
  logic [QB-1:0] q_rdx, q_rdy, q_bdx, q_bdy, q_tdx, q_tdy;
  logic          o_rdx, o_rdy, o_bdx, o_bdy, o_tdx, o_tdy;
  logic          vd;
  logic [NGW-1:0] ngd_bits;
  neg_t           ngd;

  // ---- output register
  neg_t         ngo_r;
  logic [W-1:0] out_range_dx_r, out_range_dy_r, out_bearing_dx_r, out_bearing_dy_r;
  logic [W-1:0] out_rate_dx_r, out_rate_dy_r;

  // valid bits of the hand-built stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      vb_r        <= 1'b0;
      vc_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      v5_r        <= v4_r;
      v6_r        <= v5_r;
      vb_r        <= va;
      vc_r        <= vb_r;
      out_valid_r <= vd;
    end
  end

  // stage 1 to 2 combinational helpers
  assign ax_nxt = x1_r[W-1] ? W'(~x1_r + W'(1)) : W'(x1_r);
  assign ay_nxt = y1_r[W-1] ? W'(~y1_r + W'(1)) : W'(y1_r);

  // stage 3 to 4 helpers
  assign sq_sum = sqx3_r + sqy3_r;
  assign c1_raw = sq_sum[2*W-1:F];
  assign d_abs  = d3_r[2*W] ? (2*W+1)'(-d3_r) : (2*W+1)'(d3_r);

  // stage 5 to 6 helpers
  assign nrx_full = {rxh5_r, {W{1'b0}}} + (3*W)'(rxl5_r);
  assign nry_full = {ryh5_r, {W{1'b0}}} + (3*W)'(ryl5_r);

  // stage b to c helpers
  assign c3_full = {phb_r, {W{1'b0}}} + (C1W+W)'(plb_r);
  assign c3_raw  = c3_full[C1W+W-1:F];

  // payload of stages 1 through 6
  always_ff @(posedge clk) begin
    if (en) begin
      x1_r   <= in_pos_x;
      y1_r   <= in_pos_y;
      vx1_r  <= in_vel_x;
      vy1_r  <= in_vel_y;

      ax2_r  <= ax_nxt;
      ay2_r  <= ay_nxt;
      xn2_r  <= x1_r[W-1];
      yn2_r  <= y1_r[W-1];
      yp2_r  <= !y1_r[W-1] && (y1_r != '0);
      pa2_r  <= (2*W)'(vx1_r) * (2*W)'(y1_r);
      pb2_r  <= (2*W)'(vy1_r) * (2*W)'(x1_r);

      sqx3_r <= (2*W)'(ax2_r) * (2*W)'(ax2_r);
      sqy3_r <= (2*W)'(ay2_r) * (2*W)'(ay2_r);
      d3_r   <= (2*W+1)'(pa2_r) - (2*W+1)'(pb2_r);
      ax3_r  <= ax2_r;
      ay3_r  <= ay2_r;
      xn3_r  <= xn2_r;
      yn3_r  <= yn2_r;
      yp3_r  <= yp2_r;

      c1_4_r <= (c1_raw < C1W'(eps_eff)) ? C1W'(eps_eff) : c1_raw;
      ad4_r  <= d_abs[2*W-1:0];
      dn4_r  <= d3_r[2*W];
      dp4_r  <= !d3_r[2*W] && (d3_r != '0);
      ax4_r  <= ax3_r;
      ay4_r  <= ay3_r;
      xn4_r  <= xn3_r;
      yn4_r  <= yn3_r;
      yp4_r  <= yp3_r;

      rxl5_r <= (2*W)'(ax4_r) * (2*W)'(ad4_r[W-1:0]);
      rxh5_r <= (2*W)'(ax4_r) * (2*W)'(ad4_r[2*W-1:W]);
      ryl5_r <= (2*W)'(ay4_r) * (2*W)'(ad4_r[W-1:0]);
      ryh5_r <= (2*W)'(ay4_r) * (2*W)'(ad4_r[2*W-1:W]);
      ax5_r  <= ax4_r;
      ay5_r  <= ay4_r;
      c1_5_r <= c1_4_r;
      ng5_r  <= '{x_neg: xn4_r, y_neg: yn4_r, y_pos: yp4_r,
                  rdx_neg: yn4_r ^ dn4_r, rdy_neg: xn4_r ^ dp4_r};

      nrx6_r <= nrx_full[3*W-1:F];
      nry6_r <= nry_full[3*W-1:F];
      ax6_r  <= ax5_r;
      ay6_r  <= ay5_r;
      c1_6_r <= c1_5_r;
      ng6_r  <= ng5_r;
    end
  end

  // range from range squared
  rmj_sqrt #(
    .ROOT_BITS(W)
  ) u_sqrt (
    .clk (clk),
    .en  (en),
    .rad ({c1_4_r, {F{1'b0}}}),
    .root(root)
  );

  // hold the remaining operands while the root settles
  assign dla_in = {ax6_r, ay6_r, c1_6_r, ng6_r, nrx6_r, nry6_r};

  rmj_delay #(
    .DEPTH   (W - 1),
    .DAT_BITS(AW)
  ) u_dly_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_vld (v6_r),
    .in_dat (dla_in),
    .out_vld(va),
    .out_dat(dla_out)
  );

  assign {axa, aya, c1a, nga, nrxa, nrya} = dla_out;

  // stage a: floor the range, then build range cubed over two stages
  always_ff @(posedge clk) begin
    if (en) begin
      c2_r   <= (root < W'(eps_eff)) ? W'(eps_eff) : root;

      plb_r  <= (2*W)'(c1a[W-1:0]) * (2*W)'(c2_r);
      phb_r  <= C1W'(c1a[C1W-1:W]) * C1W'(c2_r);
      axb_r  <= axa;
      ayb_r  <= aya;
      c1b_r  <= c1a;
      c2b_r  <= c2_r;
      ngb_r  <= nga;
      nrxb_r <= nrxa;
      nryb_r <= nrya;

      c3c_r  <= (c3_raw < C3W'(eps_eff)) ? C3W'(eps_eff) : c3_raw;
      axc_r  <= axb_r;
      ayc_r  <= ayb_r;
      c1c_r  <= c1b_r;
      c2c_r  <= c2b_r;
      ngc_r  <= ngb_r;
      nrxc_r <= nrxb_r;
      nryc_r <= nryb_r;
    end
  end

  // six dividers in parallel
  rmj_div #(.NUM_BITS(W + F), .DEN_BITS(W), .QUO_BITS(QB)) u_div_rdx (
    .clk(clk), .en(en), .num({axc_r, {F{1'b0}}}), .den(c2c_r), .quo(q_rdx), .ovf(o_rdx)
  );
  rmj_div #(.NUM_BITS(W + F), .DEN_BITS(W), .QUO_BITS(QB)) u_div_rdy (
    .clk(clk), .en(en), .num({ayc_r, {F{1'b0}}}), .den(c2c_r), .quo(q_rdy), .ovf(o_rdy)
  );
  rmj_div #(.NUM_BITS(W + F), .DEN_BITS(C1W), .QUO_BITS(QB)) u_div_bdx (
    .clk(clk), .en(en), .num({ayc_r, {F{1'b0}}}), .den(c1c_r), .quo(q_bdx), .ovf(o_bdx)
  );
  rmj_div #(.NUM_BITS(W + F), .DEN_BITS(C1W), .QUO_BITS(QB)) u_div_bdy (
    .clk(clk), .en(en), .num({axc_r, {F{1'b0}}}), .den(c1c_r), .quo(q_bdy), .ovf(o_bdy)
  );
  rmj_div #(.NUM_BITS(NRW), .DEN_BITS(C3W), .QUO_BITS(QB)) u_div_tdx (
    .clk(clk), .en(en), .num(nryc_r), .den(c3c_r), .quo(q_tdx), .ovf(o_tdx)
  );
  rmj_div #(.NUM_BITS(NRW), .DEN_BITS(C3W), .QUO_BITS(QB)) u_div_tdy (
    .clk(clk), .en(en), .num(nrxc_r), .den(c3c_r), .quo(q_tdy), .ovf(o_tdy)
  );

  // carry signs and valid across the dividers
  rmj_delay #(
    .DEPTH   (QB + 1),
    .DAT_BITS(NGW)
  ) u_dly_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_vld (vc_r),
    .in_dat (ngc_r),
    .out_vld(vd),
    .out_dat(ngd_bits)
  );

  assign ngd = ngd_bits;

  // output register: saturate and sign each entry
  always_ff @(posedge clk) begin
    if (en) begin
      ngo_r            <= ngd;
      out_range_dx_r   <= sat_pack(ngd.x_neg,   q_rdx, o_rdx);
      out_range_dy_r   <= sat_pack(ngd.y_neg,   q_rdy, o_rdy);
      out_bearing_dx_r <= sat_pack(ngd.y_pos,   q_bdx, o_bdx);
      out_bearing_dy_r <= sat_pack(ngd.x_neg,   q_bdy, o_bdy);
      out_rate_dx_r    <= sat_pack(ngd.rdx_neg, q_tdx, o_tdx);
      out_rate_dy_r    <= sat_pack(ngd.rdy_neg, q_tdy, o_tdy);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_range_dx   = out_range_dx_r;
  assign out_range_dy   = out_range_dy_r;
  assign out_bearing_dx = out_bearing_dx_r;
  assign out_bearing_dy = out_bearing_dy_r;
  assign out_rate_dx    = out_rate_dx_r;
  assign out_rate_dy    = out_rate_dy_r;

  // floors reach every divisor that enters the dividers
  `RMJ_ASSERT_NOW(a_c3_floor, vc_r, (c3c_r >= C3W'(eps_eff)) && (c2c_r >= W'(eps_eff)), "range cubed or range below floor")
  // a positive-signed entry never leaves with its sign bit set
  `RMJ_ASSERT_NOW(a_pos_sign, out_valid_r && !ngo_r.x_neg, !out_range_dx_r[W-1] && !out_bearing_dy_r[W-1], "positive entry has sign bit set")
  // a stalled output freezes the last divider stage
  `RMJ_ASSERT_NEXT(a_stall_hold, out_valid_r && !out_ready, $stable(q_rdx) && $stable(vd), "divider moved during stall")

endmodule
`default_nettype wire

// File: sv/rmj_delay.sv
// Enabled shift line with a reset valid bit beside each data stage
`timescale 1ns / 1ps
`default_nettype none
module rmj_delay #(
  parameter int DEPTH    = 4,
  parameter int DAT_BITS = 8
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                en,
  input  wire logic                in_vld,
  input  wire logic [DAT_BITS-1:0] in_dat,
  output logic                     out_vld,
  output logic      [DAT_BITS-1:0] out_dat
);

  logic                vld_r [DEPTH];
  logic [DAT_BITS-1:0] dat_r [DEPTH];

  genvar g;
  for (g = 0; g < DEPTH; g++) begin : g_tap
    logic                vld_in;
    logic [DAT_BITS-1:0] dat_in;
    if (g == 0) begin : g_first
      assign vld_in = in_vld;
      assign dat_in = in_dat;
    end else begin : g_next
      assign vld_in = vld_r[g-1];
      assign dat_in = dat_r[g-1];
    end

    // advance valid on enable
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else if (en) begin
        vld_r[g] <= vld_in;
      end
    end

    // advance data on enable
    always_ff @(posedge clk) begin
      if (en) begin
        dat_r[g] <= dat_in;
      end
    end
  end

  assign out_vld = vld_r[DEPTH-1];
  assign out_dat = dat_r[DEPTH-1];

endmodule
`default_nettype wire

// File: sv/rmj_sqrt.sv
// Pipelined integer square root, one root bit per stage
`timescale 1ns / 1ps
`default_nettype none
module rmj_sqrt #(
  parameter int ROOT_BITS = 32
) (
  input  wire logic                   clk,
  input  wire logic                   en,
  input  wire logic [2*ROOT_BITS-1:0] rad,
  output logic      [ROOT_BITS-1:0]   root
);

  localparam int RB = ROOT_BITS;
  localparam int VB = 2 * ROOT_BITS;
  localparam int RW = ROOT_BITS + 2;

  logic [RW-1:0] rem_r  [RB];
  logic [RB-1:0] root_r [RB];
  logic [VB-1:0] rad_r  [RB];

  genvar g;
  for (g = 0; g < RB; g++) begin : g_step
    logic [RW-1:0] rem_in;
    logic [RB-1:0] root_in;
    logic [VB-1:0] rad_in;
    logic [RW-1:0] r2;
    logic [RW-1:0] trial;
    logic [RW-1:0] rem_nxt;
    logic [RB-1:0] root_nxt;

    if (g == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad;
    end else begin : g_next
      assign rem_in  = rem_r[g-1];
      assign root_in = root_r[g-1];
      assign rad_in  = rad_r[g-1];
    end

    // bring down two radicand bits, try 4*root+1
    always_comb begin
      r2    = {rem_in[RW-3:0], rad_in[VB-1 -: 2]};
      trial = {root_in, 2'b01};
      if (r2 >= trial) begin
        rem_nxt  = r2 - trial;
        root_nxt = {root_in[RB-2:0], 1'b1};
      end else begin
        rem_nxt  = r2;
        root_nxt = {root_in[RB-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g]  <= rem_nxt;
        root_r[g] <= root_nxt;
        rad_r[g]  <= {rad_in[VB-3:0], 2'b00};
      end
    end
  end

  assign root = root_r[RB-1];

endmodule
`default_nettype wire

// File: sv/rmj_div.sv
// Pipelined restoring divider with quotient overflow flag, one bit per stage
`timescale 1ns / 1ps
`default_nettype none
module rmj_div #(
  parameter int NUM_BITS = 48,
  parameter int DEN_BITS = 32,
  parameter int QUO_BITS = 33
) (
  input  wire logic                clk,
  input  wire logic                en,
  input  wire logic [NUM_BITS-1:0] num,
  input  wire logic [DEN_BITS-1:0] den,
  output logic      [QUO_BITS-1:0] quo,
  output logic                     ovf
);

  localparam int NB = NUM_BITS;
  localparam int DB = DEN_BITS;
  localparam int QB = QUO_BITS;
  localparam int HB = NUM_BITS - QUO_BITS;
  localparam int CB = (HB > DB) ? HB : DB;

  logic [HB-1:0] hi;
  logic          pre_ovf_nxt;

  logic          pre_ovf_r;
  logic [DB-1:0] pre_rem_r;
  logic [QB-1:0] pre_lo_r;
  logic [DB-1:0] pre_den_r;

  logic [DB-1:0] rem_r [QB];
  logic [QB-1:0] lo_r  [QB];
  logic [QB-1:0] quo_r [QB];
  logic [DB-1:0] den_r [QB];
  logic          ovf_r [QB];

  // flag quotients that do not fit, start remainder from the top part
  assign hi          = num[NB-1:QB];
  assign pre_ovf_nxt = CB'(hi) >= CB'(den);

  always_ff @(posedge clk) begin
    if (en) begin
      pre_ovf_r <= pre_ovf_nxt;
      pre_rem_r <= pre_ovf_nxt ? '0 : DB'(hi);
      pre_lo_r  <= num[QB-1:0];
      pre_den_r <= den;
    end
  end

  genvar g;
  for (g = 0; g < QB; g++) begin : g_step
    logic [DB-1:0] rem_in;
    logic [QB-1:0] lo_in;
    logic [QB-1:0] quo_in;
    logic [DB-1:0] den_in;
    logic          ovf_in;
    logic [DB:0]   r2;
    logic [DB-1:0] rem_nxt;
    logic          bit_nxt;

    if (g == 0) begin : g_first
      assign rem_in = pre_rem_r;
      assign lo_in  = pre_lo_r;
      assign quo_in = '0;
      assign den_in = pre_den_r;
      assign ovf_in = pre_ovf_r;
    end else begin : g_next
      assign rem_in = rem_r[g-1];
      assign lo_in  = lo_r[g-1];
      assign quo_in = quo_r[g-1];
      assign den_in = den_r[g-1];
      assign ovf_in = ovf_r[g-1];
    end

    // shift in one numerator bit, subtract when it fits
    always_comb begin
      r2 = {rem_in, lo_in[QB-1]};
      if (r2 >= {1'b0, den_in}) begin
        rem_nxt = DB'(r2 - {1'b0, den_in});
        bit_nxt = 1'b1;
      end else begin
        rem_nxt = r2[DB-1:0];
        bit_nxt = 1'b0;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g] <= rem_nxt;
        lo_r[g]  <= {lo_in[QB-2:0], 1'b0};
        quo_r[g] <= {quo_in[QB-2:0], bit_nxt};
        den_r[g] <= den_in;
        ovf_r[g] <= ovf_in;
      end
    end
  end

  assign quo = quo_r[QB-1];
  assign ovf = ovf_r[QB-1];

endmodule
`default_nettype wire
